// ===== rtl/rc2mc_pkg.sv =====
// Shared types, constants and register map for the RC channel to motion command block.
`default_nettype none

package rc2mc_pkg;

	localparam int PULSE_W           = 12;
	localparam int MAXV_W            = 12;
	localparam int STEP_W            = 15;
	localparam int VEL_W             = 16;
	localparam int VELOCITY_BITS_DEF = 16;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// stick arithmetic
	localparam int DIFF_W      = PULSE_W + 1;
	localparam int PROD_FULL_W = 2 * DIFF_W;
	localparam int PROD_W      = 24;
	localparam int QUOT_N_W    = PROD_W - 2;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 29;
	localparam int QUOT_W      = QUOT_N_W + RECIP_W - RECIP_SHIFT;
	// ceil(2^29 / 125): exact floor(n / 125) for n < 2^22
	localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;

	// switch windows, all strict
	localparam logic [PULSE_W-1:0] SW_LO_MIN  = 12'd950;
	localparam logic [PULSE_W-1:0] SW_LO_MAX  = 12'd1050;
	localparam logic [PULSE_W-1:0] SW_MID_MIN = 12'd1450;
	localparam logic [PULSE_W-1:0] SW_MID_MAX = 12'd1550;
	localparam logic [PULSE_W-1:0] SW_HI_MIN  = 12'd1950;
	localparam logic [PULSE_W-1:0] SW_HI_MAX  = 12'd2050;

	// stick deadband
	localparam logic [PULSE_W-1:0] DB_MIN       = 12'd1400;
	localparam logic [PULSE_W-1:0] DB_MAX       = 12'd1600;
	localparam logic [PULSE_W-1:0] STICK_CENTRE = 12'd1500;

	localparam logic [MAXV_W-1:0] MAXV_RST = 12'd1024;
	localparam logic [STEP_W-1:0] STEP_RST = 15'd64;

	// switch position codes
	localparam logic       POS2_UPPER  = 1'b0;
	localparam logic       POS2_LOWER  = 1'b1;
	localparam logic [1:0] POS3_UPPER  = 2'd0;
	localparam logic [1:0] POS3_MIDDLE = 2'd1;
	localparam logic [1:0] POS3_LOWER  = 2'd2;

	typedef enum logic [1:0] {
		REG_FULL_SCALE = 2'd0,
		REG_MAX_STEP   = 2'd1,
		REG_USE_RAMP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PULSE_W-1:0] switch_a;
		logic [PULSE_W-1:0] switch_b;
		logic [PULSE_W-1:0] switch_c;
		logic [PULSE_W-1:0] switch_d;
		logic [PULSE_W-1:0] left_horizontal;
		logic [PULSE_W-1:0] left_vertical;
		logic [PULSE_W-1:0] right_horizontal;
	} frame_t;

	typedef struct packed {
		logic              external_source;
		logic [1:0]        run_status;
		logic [1:0]        move_mode;
		logic              control_select;
		logic signed [VEL_W-1:0] forward_velocity;
		logic signed [VEL_W-1:0] lateral_velocity;
		logic signed [VEL_W-1:0] turn_rate;
	} command_t;

	typedef struct packed {
		logic       external_source;
		logic [1:0] run_status;
		logic [1:0] move_mode;
		logic       control_select;
	} switch_codes_t;

	typedef struct packed {
		logic [MAXV_W-1:0] full_scale;
		logic [STEP_W-1:0] max_step;
		logic              use_ramp;
	} cfg_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/rc2mc_stream_if.sv =====
// Valid/ready word channel used for the frame input and the command output.
`default_nettype none

interface rc2mc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rc2mc_regs.sv =====
// APB configuration registers: full-scale velocity, max_step, use_ramp.
`default_nettype none

module rc2mc_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rc2mc_pkg::APB_AW-1:0] paddr,
	input  wire logic [rc2mc_pkg::APB_DW-1:0] pwdata,
	output logic      [rc2mc_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	output rc2mc_pkg::cfg_t                  cfg
);
	import rc2mc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale <= MAXV_RST;
			cfg_q.max_step   <= STEP_RST;
			cfg_q.use_ramp   <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_FULL_SCALE: cfg_q.full_scale <= pwdata[MAXV_W-1:0];
				REG_MAX_STEP:   cfg_q.max_step   <= pwdata[STEP_W-1:0];
				REG_USE_RAMP:   cfg_q.use_ramp   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FULL_SCALE: prdata = APB_DW'(cfg_q.full_scale);
			REG_MAX_STEP:   prdata = APB_DW'(cfg_q.max_step);
			REG_USE_RAMP:   prdata = APB_DW'(cfg_q.use_ramp);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rc2mc_switch.sv =====
// Switch window decode with held position codes.
`default_nettype none

module rc2mc_switch (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     load,
	input  rc2mc_pkg::frame_t             frame_data,
	output rc2mc_pkg::switch_codes_t      codes
);
	import rc2mc_pkg::*;

	switch_codes_t held_q;

	function automatic logic in_win(input logic [PULSE_W-1:0] p,
		input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
		return (p > lo) && (p < hi);
	endfunction

	function automatic logic dec_two(input logic [PULSE_W-1:0] p, input logic held);
		logic r;
		r = held;
		if (in_win(p, SW_LO_MIN, SW_LO_MAX)) r = POS2_UPPER;
		if (in_win(p, SW_HI_MIN, SW_HI_MAX)) r = POS2_LOWER;
		return r;
	endfunction

	function automatic logic [1:0] dec_three(input logic [PULSE_W-1:0] p,
		input logic [1:0] held);
		logic [1:0] r;
		r = held;
		if (in_win(p, SW_LO_MIN, SW_LO_MAX))   r = POS3_UPPER;
		if (in_win(p, SW_MID_MIN, SW_MID_MAX)) r = POS3_MIDDLE;
		if (in_win(p, SW_HI_MIN, SW_HI_MAX))   r = POS3_LOWER;
		return r;
	endfunction

	always_comb begin
		codes.external_source = dec_two(frame_data.switch_a, held_q.external_source);
		codes.run_status      = dec_three(frame_data.switch_b, held_q.run_status);
		codes.move_mode       = dec_three(frame_data.switch_c, held_q.move_mode);
		codes.control_select  = dec_two(frame_data.switch_d, held_q.control_select);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (load) begin
			held_q <= codes;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rc2mc_scale.sv =====
// One stick lane: deadband, scale by full-scale velocity, divide by 500, saturate, sign.
`default_nettype none

module rc2mc_scale #(
	parameter int VELOCITY_BITS = rc2mc_pkg::VELOCITY_BITS_DEF
) (
	input  wire logic                              clk,
	input  rc2mc_pkg::stage_en_t                   en,
	input  wire logic [rc2mc_pkg::PULSE_W-1:0]     stick,
	input  wire logic [rc2mc_pkg::MAXV_W-1:0]      full_scale,
	input  wire logic                              negate,
	output logic signed [VELOCITY_BITS-1:0]        vel
);
	import rc2mc_pkg::*;

	localparam logic [32:0] VelLim = (33'd1 << (VELOCITY_BITS - 1)) - 33'd1;

	logic [PULSE_W-1:0]            snapped;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_FULL_W-1:0] prod;
	logic signed [PROD_FULL_W-1:0] prod_abs;

	logic [PROD_W-1:0]             mag_s2;
	logic                          neg_s2;

	logic [QUOT_N_W+RECIP_W-1:0]   recip_prod;
	logic [QUOT_W-1:0]             quot;
	logic [32:0]                   quot_w;
	logic [32:0]                   sat;
	logic signed [VELOCITY_BITS-1:0] mag_v;
	logic signed [VELOCITY_BITS-1:0] vel_next;
	logic signed [VELOCITY_BITS-1:0] vel_s3;

	// stage 2: deadband snap and product
	assign snapped  = (stick > DB_MIN && stick < DB_MAX) ? STICK_CENTRE : stick;
	assign diff     = $signed({1'b0, snapped}) - $signed({1'b0, STICK_CENTRE});
	assign prod     = diff * $signed({1'b0, full_scale});
	assign prod_abs = prod[PROD_FULL_W-1] ? -prod : prod;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= prod_abs[PROD_W-1:0];
			neg_s2 <= prod[PROD_FULL_W-1] ^ negate;
		end
	end

	// stage 3: /500 as >>2 then reciprocal of 125, truncating toward zero
	assign recip_prod = mag_s2[PROD_W-1:2] * RECIP_125;
	assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
	assign quot_w     = 33'(quot);
	assign sat        = (quot_w > VelLim) ? VelLim : quot_w;
	assign mag_v      = $signed(sat[VELOCITY_BITS-1:0]);
	assign vel_next   = neg_s2 ? -mag_v : mag_v;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			vel_s3 <= vel_next;
		end
	end

	assign vel = vel_s3;

endmodule

`default_nettype wire

// ===== rtl/rc2mc_slew.sv =====
// One axis slew limiter with its ramp state.
`default_nettype none

module rc2mc_slew #(
	parameter int VELOCITY_BITS = rc2mc_pkg::VELOCITY_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire logic                          use_ramp,
	input  wire logic [rc2mc_pkg::STEP_W-1:0]  max_step,
	input  wire logic signed [VELOCITY_BITS-1:0] target,
	output logic signed [VELOCITY_BITS-1:0]    result
);
	import rc2mc_pkg::*;

	localparam int SW = (VELOCITY_BITS + 1 > STEP_W + 1) ? VELOCITY_BITS + 1 : STEP_W + 1;

	logic signed [VELOCITY_BITS-1:0] ramp_q;
	logic signed [SW-1:0] t_w;
	logic signed [SW-1:0] c_w;
	logic signed [SW-1:0] st_w;
	logic signed [SW-1:0] d_w;
	logic signed [SW-1:0] ad_w;
	logic signed [SW-1:0] nxt_w;
	logic signed [VELOCITY_BITS-1:0] nxt;

	assign t_w  = SW'(target);
	assign c_w  = SW'(ramp_q);
	assign st_w = $signed(SW'(max_step));
	assign d_w  = t_w - c_w;
	assign ad_w = d_w[SW-1] ? -d_w : d_w;

	always_comb begin
		priority if (ad_w < st_w) begin
			nxt_w = t_w;
		end else if (c_w < t_w) begin
			nxt_w = c_w + st_w;
		end else begin
			nxt_w = c_w - st_w;
		end
	end

	assign nxt    = nxt_w[VELOCITY_BITS-1:0];
	assign result = use_ramp ? nxt : target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= '0;
		end else if (upd && use_ramp) begin
			ramp_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rc_channel_to_motion_command.sv =====
// Top level: RC frame to motion command, four-register pipeline with APB configuration.
//
// One frame word enters per cycle while ready is high; one command word leaves per frame,
// after the input, product, quotient and output registers. The stick path sets this depth:
// the full-scale product and the reciprocal multiply for the divide by 500 each take a
// stage of their own. Ready stalls only when every stage holds a word and the output word
// is not taken. Switch codes and ramp state update in frame order; the user must write
// configuration only while the pipeline is empty, which the block does not enforce.
`default_nettype none

module rc_channel_to_motion_command #(
	parameter int VELOCITY_BITS = rc2mc_pkg::VELOCITY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	rc2mc_stream_if.sink                      frame,
	rc2mc_stream_if.source                    command,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rc2mc_pkg::APB_AW-1:0] paddr,
	input  wire logic [rc2mc_pkg::APB_DW-1:0] pwdata,
	output logic      [rc2mc_pkg::APB_DW-1:0] prdata,
	output logic                              pready
);
	import rc2mc_pkg::*;

	cfg_t          cfg;
	switch_codes_t codes;
	switch_codes_t codes_s1;
	switch_codes_t codes_s2;
	switch_codes_t codes_s3;
	frame_t        frame_s1;
	command_t      cmd_q;
	stage_en_t     en;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic out_vld_q;
	logic accept;
	logic out_adv;
	logic free_s3;
	logic free_s2;
	logic free_s1;
	logic take_out;

	logic [PULSE_W-1:0]              sticks [3];
	logic                            neg_lane [3];
	logic signed [VELOCITY_BITS-1:0] vel_s3 [3];
	logic signed [VELOCITY_BITS-1:0] slew_res [3];
	logic [VEL_W-1:0]                vel_out [3];

	// pipeline flow
	assign out_adv  = !out_vld_q || command.ready;
	assign free_s3  = !vld_s3 || out_adv;
	assign free_s2  = !vld_s2 || free_s3;
	assign free_s1  = !vld_s1 || free_s2;
	assign take_out = vld_s3 && out_adv;
	assign en.s2    = vld_s1 && free_s2;
	assign en.s3    = vld_s2 && free_s3;

	assign frame.ready = free_s1;
	assign accept      = frame.valid && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (free_s1) vld_s1 <= frame.valid;
			if (free_s2) vld_s2 <= vld_s1;
			if (free_s3) vld_s3 <= vld_s2;
			if (out_adv) out_vld_q <= vld_s3;
		end
	end

	rc2mc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rc2mc_switch u_switch (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.frame_data (frame.data),
		.codes      (codes)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame.data;
			codes_s1 <= codes;
		end
		if (en.s2) codes_s2 <= codes_s1;
		if (en.s3) codes_s3 <= codes_s2;
	end

	// lanes: forward, lateral (negated), turn
	assign sticks[0]   = frame_s1.left_vertical;
	assign sticks[1]   = frame_s1.left_horizontal;
	assign sticks[2]   = frame_s1.right_horizontal;
	assign neg_lane[0] = 1'b0;
	assign neg_lane[1] = 1'b1;
	assign neg_lane[2] = 1'b0;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rc2mc_scale #(
			.VELOCITY_BITS (VELOCITY_BITS)
		) u_scale (
			.clk        (clk),
			.en         (en),
			.stick      (sticks[i]),
			.full_scale (cfg.full_scale),
			.negate     (neg_lane[i]),
			.vel        (vel_s3[i])
		);

		rc2mc_slew #(
			.VELOCITY_BITS (VELOCITY_BITS)
		) u_slew (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (take_out),
			.use_ramp (cfg.use_ramp),
			.max_step (cfg.max_step),
			.target   (vel_s3[i]),
			.result   (slew_res[i])
		);

		assign vel_out[i] = VEL_W'(32'($unsigned(slew_res[i])));
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			cmd_q.external_source  <= codes_s3.external_source;
			cmd_q.run_status       <= codes_s3.run_status;
			cmd_q.move_mode        <= codes_s3.move_mode;
			cmd_q.control_select   <= codes_s3.control_select;
			cmd_q.forward_velocity <= $signed(vel_out[0]);
			cmd_q.lateral_velocity <= $signed(vel_out[1]);
			cmd_q.turn_rate        <= $signed(vel_out[2]);
		end
	end

	assign command.valid = out_vld_q;
	assign command.data  = cmd_q;

endmodule

`default_nettype wire

// ===== tb/sv/rc2mc_command_checker.sv =====
// Checker for the RC frame to motion command block: predicts every command word and compares it.
`timescale 1ns / 100ps

import rc2mc_pkg::*;

module rc2mc_command_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	input  logic                frame_ready,
	input  frame_t              frame_data,
	input  logic                command_valid,
	input  logic                command_ready,
	input  command_t            command_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output int                  errors,
	output int                  pending
);

	localparam int VEL_LIMIT = (1 << (VEL_W - 1)) - 1;

	logic [MAXV_W-1:0] cfg_full_scale;
	logic [STEP_W-1:0] cfg_max_step;
	logic              cfg_use_ramp;

	logic       held_source;
	logic [1:0] held_status;
	logic [1:0] held_move;
	logic       held_select;
	int         slewed_velocity [0:2];

	command_t expected_commands [$];
	command_t want;
	int       mismatch_count;

	assign errors = mismatch_count;

	initial mismatch_count = 0;

	function automatic logic [1:0] decode_switch(input logic [PULSE_W-1:0] p,
			input logic [1:0] held, input bit three_pos);
		logic [1:0] code;
		code = held;
		if (p > SW_LO_MIN && p < SW_LO_MAX)
			code = three_pos ? POS3_UPPER : {1'b0, POS2_UPPER};
		if (three_pos && p > SW_MID_MIN && p < SW_MID_MAX)
			code = POS3_MIDDLE;
		if (p > SW_HI_MIN && p < SW_HI_MAX)
			code = three_pos ? POS3_LOWER : {1'b0, POS2_LOWER};
		return code;
	endfunction

	// deadband snap, then scale by full scale / 500, truncating toward zero
	function automatic int stick_velocity(input logic [PULSE_W-1:0] p);
		int diff;
		int v;
		if (p > DB_MIN && p < DB_MAX)
			diff = 0;
		else
			diff = int'(p) - int'(STICK_CENTRE);
		v = diff * int'(cfg_full_scale) / 500;
		if (v > VEL_LIMIT)
			v = VEL_LIMIT;
		if (v < -VEL_LIMIT)
			v = -VEL_LIMIT;
		return v;
	endfunction

	function automatic int slew_toward(input int cur, input int target);
		int d;
		int step;
		step = int'(cfg_max_step);
		d = target - cur;
		if (d < 0)
			d = -d;
		if (d < step)
			return target;
		if (cur < target)
			return cur + step;
		return cur - step;
	endfunction

	function automatic command_t predict_command(input frame_t f);
		int       v [0:2];
		command_t c;
		logic [1:0] code;
		code = decode_switch(f.switch_a, {1'b0, held_source}, 1'b0);
		held_source = code[0];
		held_status = decode_switch(f.switch_b, held_status, 1'b1);
		held_move = decode_switch(f.switch_c, held_move, 1'b1);
		code = decode_switch(f.switch_d, {1'b0, held_select}, 1'b0);
		held_select = code[0];
		v[0] = stick_velocity(f.left_vertical);
		v[1] = -stick_velocity(f.left_horizontal);
		v[2] = stick_velocity(f.right_horizontal);
		if (cfg_use_ramp) begin
			for (int i = 0; i < 3; i++) begin
				slewed_velocity[i] = slew_toward(slewed_velocity[i], v[i]);
				v[i] = slewed_velocity[i];
			end
		end
		c.external_source = held_source;
		c.run_status = held_status;
		c.move_mode = held_move;
		c.control_select = held_select;
		c.forward_velocity = v[0][VEL_W-1:0];
		c.lateral_velocity = v[1][VEL_W-1:0];
		c.turn_rate = v[2][VEL_W-1:0];
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_v);
		$display("%0t: command %s mismatch: got %0d, expected %0d", $time, what, got, exp_v);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_full_scale <= MAXV_RST;
			cfg_max_step <= STEP_RST;
			cfg_use_ramp <= 1'b0;
			held_source = POS2_UPPER;
			held_status = POS3_UPPER;
			held_move = POS3_UPPER;
			held_select = POS2_UPPER;
			for (int i = 0; i < 3; i++)
				slewed_velocity[i] = 0;
			expected_commands.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_FULL_SCALE: cfg_full_scale <= pwdata[MAXV_W-1:0];
					REG_MAX_STEP:   cfg_max_step <= pwdata[STEP_W-1:0];
					REG_USE_RAMP:   cfg_use_ramp <= pwdata[0];
					default: ;
				endcase
			end
			if (frame_valid && frame_ready)
				expected_commands.push_back(predict_command(frame_data));
			if (command_valid && command_ready) begin
				if (expected_commands.size() == 0) begin
					report_mismatch("word with none outstanding", 1, 0);
				end else begin
					want = expected_commands.pop_front();
					if (command_data.external_source !== want.external_source)
						report_mismatch("external_source", command_data.external_source,
							want.external_source);
					if (command_data.run_status !== want.run_status)
						report_mismatch("run_status", command_data.run_status,
							want.run_status);
					if (command_data.move_mode !== want.move_mode)
						report_mismatch("move_mode", command_data.move_mode,
							want.move_mode);
					if (command_data.control_select !== want.control_select)
						report_mismatch("control_select", command_data.control_select,
							want.control_select);
					if (command_data.forward_velocity !== want.forward_velocity)
						report_mismatch("forward_velocity",
							int'($signed(command_data.forward_velocity)),
							int'($signed(want.forward_velocity)));
					if (command_data.lateral_velocity !== want.lateral_velocity)
						report_mismatch("lateral_velocity",
							int'($signed(command_data.lateral_velocity)),
							int'($signed(want.lateral_velocity)));
					if (command_data.turn_rate !== want.turn_rate)
						report_mismatch("turn_rate", int'($signed(command_data.turn_rate)),
							int'($signed(want.turn_rate)));
				end
			end
			pending <= expected_commands.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives frames, configuration and output stalls, and gives the verdict.
`timescale 1ns / 100ps

import rc2mc_pkg::*;

module tb;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int FRAMES_PER_PHASE = 200;
	localparam int NUM_PHASES       = 8;
	localparam int DRAIN_CYCLES     = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int src_idle_pct;
	int sink_stall_pct;
	int idle_cycles = 0;
	int errors;
	int pending;

	logic [PULSE_W-1:0] edge_pulses [0:19] = '{12'd0, 12'd4095, 12'd950, 12'd951,
		12'd1000, 12'd1049, 12'd1050, 12'd1450, 12'd1451, 12'd1500, 12'd1549, 12'd1550,
		12'd1950, 12'd1951, 12'd2000, 12'd2049, 12'd2050, 12'd949, 12'd2051, 12'd1200};
	logic [PULSE_W-1:0] stick_pulses [0:19] = '{12'd4095, 12'd0, 12'd1000, 12'd2000,
		12'd1399, 12'd1400, 12'd1401, 12'd1599, 12'd1600, 12'd1601, 12'd1500, 12'd1499,
		12'd1501, 12'd1100, 12'd1900, 12'd3000, 12'd500, 12'd2047, 12'd2048, 12'd1234};

	rc2mc_stream_if #(.T(frame_t))   frame_ch ();
	rc2mc_stream_if #(.T(command_t)) command_ch ();

	rc_channel_to_motion_command u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.command (command_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rc2mc_command_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_valid   (frame_ch.valid),
		.frame_ready   (frame_ch.ready),
		.frame_data    (frame_ch.data),
		.command_valid (command_ch.valid),
		.command_ready (command_ch.ready),
		.command_data  (command_ch.data),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk)
		command_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (command_ch.valid && command_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly inside a window, some right on an edge, the rest anywhere
	function automatic logic [PULSE_W-1:0] random_switch();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return 12'(1000 + 500 * $urandom_range(2) + $urandom_range(98) - 49);
		if (sel == 6)
			return 12'(edge_pulses[2 + $urandom_range(14)] + $urandom_range(2) - 1);
		return 12'($urandom_range(4095));
	endfunction

	function automatic logic [PULSE_W-1:0] random_stick();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5)
			return 12'($urandom_range(2100, 900));
		if (sel == 5)
			return 12'((($urandom_range(1)) ? 1400 : 1600) + $urandom_range(2) - 1);
		if (sel == 6)
			return 12'($urandom_range(1600, 1400));
		return 12'($urandom_range(4095));
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		f.switch_a = random_switch();
		f.switch_b = random_switch();
		f.switch_c = random_switch();
		f.switch_d = random_switch();
		f.left_horizontal = random_stick();
		f.left_vertical = random_stick();
		f.right_horizontal = random_stick();
		return f;
	endfunction

	// entered and left at a falling edge
	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < src_idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data <= f;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// leaves psel high; the caller ends the transfer
	task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_settings(input int maxv, input int step, input bit ramp);
		frame_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_register(REG_FULL_SCALE, APB_DW'(maxv));
		write_register(REG_MAX_STEP, APB_DW'(step));
		write_register(REG_USE_RAMP, APB_DW'(ramp));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		frame_t f;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window edges on every switch, deadband edges and extremes on every stick
		for (int i = 0; i < 20; i++) begin
			f.switch_a = edge_pulses[i];
			f.switch_b = edge_pulses[(i + 3) % 20];
			f.switch_c = edge_pulses[(i + 7) % 20];
			f.switch_d = edge_pulses[(i + 11) % 20];
			f.left_horizontal = stick_pulses[i];
			f.left_vertical = stick_pulses[(i + 1) % 20];
			f.right_horizontal = stick_pulses[(i + 5) % 20];
			send_frame(f);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: apply_settings(1024, 64, 1'b1);
				1: apply_settings(4095, 0, 1'b1);
				2: apply_settings(0, 32767, 1'b1);
				3: apply_settings(4095, 1, 1'b1);
				4: apply_settings(4095, 32767, 1'b0);
				5: apply_settings($urandom_range(4095), $urandom_range(200), 1'b1);
				6: apply_settings(0, 5, 1'b0);
				default: apply_settings($urandom_range(4095), $urandom_range(32767), 1'b1);
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
				default: begin src_idle_pct = 16; sink_stall_pct = 16; end
			endcase
			for (int n = 0; n < FRAMES_PER_PHASE; n++)
				send_frame(random_frame());
		end

		frame_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
